### hw/rtl/sphere_obstacle_collision_table_defines.svh
// Assertion macros shared by the sphere obstacle table RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef SPHERE_OBSTACLE_COLLISION_TABLE_DEFINES_SVH
`define SPHERE_OBSTACLE_COLLISION_TABLE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SOCT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("soct implication check failed");

// Condition that must hold at every clock edge outside reset.
`define SOCT_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("soct invariant check failed");

`endif

### hw/rtl/soct_pkg.sv
// Package for the sphere obstacle table: item and result types, command codes,
// arithmetic widths and the control word of the shared multiply-accumulate unit.
// No dependencies.
`default_nettype none

package soct_pkg;

    // Default values of the top level parameters.
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int COORD_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int FIELD_W = 16;
    localparam int CMD_W   = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POINT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEG    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SIGHT  = 2'd3;

    localparam logic [FIELD_W-1:0] MARGIN_RESET = 16'd1;

    // Arithmetic widths: coordinate differences, multiplier operands,
    // products and the accumulator.
    localparam int DIFF_W = 17;
    localparam int OP_W   = 19;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = 72;

    // Shift codes applied to a product before accumulation.
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_18 = 2'd1;
    localparam logic [1:0] SH_19 = 2'd2;
    localparam logic [1:0] SH_36 = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] start_z;
        logic signed [FIELD_W-1:0] end_x;
        logic signed [FIELD_W-1:0] end_y;
        logic signed [FIELD_W-1:0] end_z;
        logic [FIELD_W-1:0]        probe_radius;
    } item_t;

    typedef struct packed {
        logic answer;
        logic table_full;
    } result_t;

    // Control word of one multiply-accumulate step.
    typedef struct packed {
        logic       valid;
        logic       clr;
        logic       neg;
        logic [1:0] sh;
    } mac_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/sphere_obstacle_collision_table.sv
// Insert and empty-table queries: result in the cycle after the item is taken. The point
// test scans every stored sphere; the segment test first computes the squared segment
// length, then scans the spheres, stopping at the first hit. The scan is set by the one
// shared multiplier, one multiply per step. One item at a time; busy is high while a query
// runs. The result strobe done lasts one cycle and cannot be stalled. Reset empties the
// table and sets the margin to 1; table contents are not cleared.
`default_nettype none
`include "sphere_obstacle_collision_table_defines.svh"

module sphere_obstacle_collision_table #(
    parameter int TABLE_DEPTH = soct_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = soct_pkg::COORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire soct_pkg::item_t               item,
    output logic                               done,
    output soct_pkg::result_t                  result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [soct_pkg::FIELD_W-1:0]  cfg_data
);

    localparam int EFF    = COORD_BITS < 16 ? COORD_BITS : 16;
    localparam int AW     = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = 3 * EFF + soct_pkg::FIELD_W;
    localparam int DW     = soct_pkg::DIFF_W;
    localparam int OW     = soct_pkg::OP_W;
    localparam int AC     = soct_pkg::ACC_W;

    // Controller states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CALC  = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;

    // Operand sources of the multiplier.
    localparam logic [4:0] SRC_WX   = 5'd0;
    localparam logic [4:0] SRC_WY   = 5'd1;
    localparam logic [4:0] SRC_WZ   = 5'd2;
    localparam logic [4:0] SRC_DX   = 5'd3;
    localparam logic [4:0] SRC_DY   = 5'd4;
    localparam logic [4:0] SRC_DZ   = 5'd5;
    localparam logic [4:0] SRC_VX   = 5'd6;
    localparam logic [4:0] SRC_VY   = 5'd7;
    localparam logic [4:0] SRC_VZ   = 5'd8;
    localparam logic [4:0] SRC_LIM  = 5'd9;
    localparam logic [4:0] SRC_LIMB = 5'd10;
    localparam logic [4:0] SRC_L2LO = 5'd11;
    localparam logic [4:0] SRC_L2HI = 5'd12;
    localparam logic [4:0] SRC_DDLO = 5'd13;
    localparam logic [4:0] SRC_DDHI = 5'd14;
    localparam logic [4:0] SRC_CXLO = 5'd15;
    localparam logic [4:0] SRC_CXHI = 5'd16;
    localparam logic [4:0] SRC_CYLO = 5'd17;
    localparam logic [4:0] SRC_CYHI = 5'd18;
    localparam logic [4:0] SRC_CZLO = 5'd19;
    localparam logic [4:0] SRC_CZHI = 5'd20;

    // Microprogram landmarks.
    localparam logic [5:0] STEP_LIM2    = 6'd0;
    localparam logic [5:0] STEP_WD      = 6'd1;
    localparam logic [5:0] STEP_WD_END  = 6'd3;
    localparam logic [5:0] STEP_SQW     = 6'd4;
    localparam logic [5:0] STEP_SQW_END = 6'd6;
    localparam logic [5:0] STEP_SQV     = 6'd7;
    localparam logic [5:0] STEP_SQV_END = 6'd9;
    localparam logic [5:0] STEP_CROSS   = 6'd10;
    localparam logic [5:0] STEP_CX_SAVE = 6'd11;
    localparam logic [5:0] STEP_CY_SAVE = 6'd13;
    localparam logic [5:0] STEP_CZ_SAVE = 6'd15;
    localparam logic [5:0] STEP_PROD    = 6'd16;
    localparam logic [5:0] STEP_CX2     = 6'd20;
    localparam logic [5:0] STEP_CY2     = 6'd23;
    localparam logic [5:0] STEP_CZ2     = 6'd26;
    localparam logic [5:0] STEP_CMP_END = 6'd28;
    localparam logic [5:0] STEP_DD      = 6'd29;
    localparam logic [5:0] STEP_DD_END  = 6'd31;
    localparam logic [5:0] STEP_PT      = 6'd32;

    typedef struct packed {
        logic [4:0] asel;
        logic [4:0] bsel;
        logic       clr;
        logic       neg;
        logic [1:0] sh;
    } step_t;

    function automatic step_t mk(input logic [4:0] a, input logic [4:0] b,
                                 input logic c, input logic n, input logic [1:0] s);
        step_t d;
        d.asel = a;
        d.bsel = b;
        d.clr  = c;
        d.neg  = n;
        d.sh   = s;
        return d;
    endfunction

    // Microprogram: one multiply-accumulate per step.
    function automatic step_t step_decode(input logic [5:0] s);
        step_t d;
        case (s)
            STEP_LIM2:          d = mk(SRC_LIM,  SRC_LIM,  1'b1, 1'b0, soct_pkg::SH_0);
            STEP_WD:            d = mk(SRC_WX,   SRC_DX,   1'b1, 1'b0, soct_pkg::SH_0);
            STEP_WD + 6'd1:     d = mk(SRC_WY,   SRC_DY,   1'b0, 1'b0, soct_pkg::SH_0);
            STEP_WD_END:        d = mk(SRC_WZ,   SRC_DZ,   1'b0, 1'b0, soct_pkg::SH_0);
            STEP_SQW:           d = mk(SRC_WX,   SRC_WX,   1'b1, 1'b0, soct_pkg::SH_0);
            STEP_SQW + 6'd1:    d = mk(SRC_WY,   SRC_WY,   1'b0, 1'b0, soct_pkg::SH_0);
            STEP_SQW_END:       d = mk(SRC_WZ,   SRC_WZ,   1'b0, 1'b0, soct_pkg::SH_0);
            STEP_SQV:           d = mk(SRC_VX,   SRC_VX,   1'b1, 1'b0, soct_pkg::SH_0);
            STEP_SQV + 6'd1:    d = mk(SRC_VY,   SRC_VY,   1'b0, 1'b0, soct_pkg::SH_0);
            STEP_SQV_END:       d = mk(SRC_VZ,   SRC_VZ,   1'b0, 1'b0, soct_pkg::SH_0);
            STEP_CROSS:         d = mk(SRC_WY,   SRC_DZ,   1'b1, 1'b0, soct_pkg::SH_0);
            STEP_CX_SAVE:       d = mk(SRC_WZ,   SRC_DY,   1'b0, 1'b1, soct_pkg::SH_0);
            STEP_CROSS + 6'd2:  d = mk(SRC_WZ,   SRC_DX,   1'b1, 1'b0, soct_pkg::SH_0);
            STEP_CY_SAVE:       d = mk(SRC_WX,   SRC_DZ,   1'b0, 1'b1, soct_pkg::SH_0);
            STEP_CROSS + 6'd4:  d = mk(SRC_WX,   SRC_DY,   1'b1, 1'b0, soct_pkg::SH_0);
            STEP_CZ_SAVE:       d = mk(SRC_WY,   SRC_DX,   1'b0, 1'b1, soct_pkg::SH_0);
            STEP_PROD:          d = mk(SRC_L2LO, SRC_DDLO, 1'b1, 1'b0, soct_pkg::SH_0);
            STEP_PROD + 6'd1:   d = mk(SRC_L2LO, SRC_DDHI, 1'b0, 1'b0, soct_pkg::SH_18);
            STEP_PROD + 6'd2:   d = mk(SRC_L2HI, SRC_DDLO, 1'b0, 1'b0, soct_pkg::SH_18);
            STEP_PROD + 6'd3:   d = mk(SRC_L2HI, SRC_DDHI, 1'b0, 1'b0, soct_pkg::SH_36);
            STEP_CX2:           d = mk(SRC_CXLO, SRC_CXLO, 1'b0, 1'b1, soct_pkg::SH_0);
            STEP_CX2 + 6'd1:    d = mk(SRC_CXLO, SRC_CXHI, 1'b0, 1'b1, soct_pkg::SH_19);
            STEP_CX2 + 6'd2:    d = mk(SRC_CXHI, SRC_CXHI, 1'b0, 1'b1, soct_pkg::SH_36);
            STEP_CY2:           d = mk(SRC_CYLO, SRC_CYLO, 1'b0, 1'b1, soct_pkg::SH_0);
            STEP_CY2 + 6'd1:    d = mk(SRC_CYLO, SRC_CYHI, 1'b0, 1'b1, soct_pkg::SH_19);
            STEP_CY2 + 6'd2:    d = mk(SRC_CYHI, SRC_CYHI, 1'b0, 1'b1, soct_pkg::SH_36);
            STEP_CZ2:           d = mk(SRC_CZLO, SRC_CZLO, 1'b0, 1'b1, soct_pkg::SH_0);
            STEP_CZ2 + 6'd1:    d = mk(SRC_CZLO, SRC_CZHI, 1'b0, 1'b1, soct_pkg::SH_19);
            STEP_CMP_END:       d = mk(SRC_CZHI, SRC_CZHI, 1'b0, 1'b1, soct_pkg::SH_36);
            STEP_DD:            d = mk(SRC_DX,   SRC_DX,   1'b1, 1'b0, soct_pkg::SH_0);
            STEP_DD + 6'd1:     d = mk(SRC_DY,   SRC_DY,   1'b0, 1'b0, soct_pkg::SH_0);
            STEP_DD_END:        d = mk(SRC_DZ,   SRC_DZ,   1'b0, 1'b0, soct_pkg::SH_0);
            STEP_PT:            d = mk(SRC_LIMB, SRC_LIMB, 1'b1, 1'b0, soct_pkg::SH_0);
            default:            d = mk(SRC_LIM,  SRC_LIM,  1'b1, 1'b0, soct_pkg::SH_0);
        endcase
        return d;
    endfunction

    // Control registers.
    logic [2:0]                    state_reg,  state_next;
    logic [5:0]                    step_reg,   step_next;
    logic                          phase_reg,  phase_next;
    logic [CW-1:0]                 idx_reg,    idx_next;
    logic [CW-1:0]                 count_reg,  count_next;
    logic [soct_pkg::FIELD_W-1:0]  margin_reg, margin_next;
    logic                          done_reg,   done_next;

    // Payload registers.
    soct_pkg::result_t             res_reg,    res_next;
    soct_pkg::item_t               q_reg,      q_next;
    logic [35:0]                   lim2_reg,   lim2_next;
    logic [33:0]                   dd_reg,     dd_next;
    logic signed [34:0]            cx_reg,     cx_next;
    logic signed [34:0]            cy_reg,     cy_next;
    logic signed [34:0]            cz_reg,     cz_next;
    logic [33:0]                   best_reg,   best_next;
    logic [soct_pkg::FIELD_W-1:0]  bsize_reg,  bsize_next;

    // Table memory and arithmetic unit signals.
    logic                          ram_we;
    logic                          ram_re;
    logic [WORD_W-1:0]             ram_wdata;
    logic [WORD_W-1:0]             ram_rdata;
    soct_pkg::mac_ctrl_t           mac_ctrl;
    logic signed [OW-1:0]          op_a;
    logic signed [OW-1:0]          op_b;
    logic signed [AC-1:0]          acc_next;
    logic signed [OW-1:0]          opnd [32];
    step_t                         cur;

    // Decoded query and entry values.
    logic signed [DW-1:0]          sx, sy, sz, ex, ey, ez;
    logic signed [DW-1:0]          cenx, ceny, cenz;
    logic signed [DW-1:0]          wx, wy, wz, vx, vy, vz, dx, dy, dz;
    logic [soct_pkg::FIELD_W-1:0]  esize;
    logic [17:0]                   lim_e, lim_b;
    logic [33:0]                   mag_x, mag_y, mag_z;
    logic                          is_point;
    logic                          full;
    logic                          last;
    logic                          ent_done;
    logic                          ent_hit;

    assign busy      = state_reg != ST_IDLE;
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    // Coordinates keep their low EFF bits, sign-extended.
    assign sx = DW'(signed'(q_reg.start_x[EFF-1:0]));
    assign sy = DW'(signed'(q_reg.start_y[EFF-1:0]));
    assign sz = DW'(signed'(q_reg.start_z[EFF-1:0]));
    assign ex = DW'(signed'(q_reg.end_x[EFF-1:0]));
    assign ey = DW'(signed'(q_reg.end_y[EFF-1:0]));
    assign ez = DW'(signed'(q_reg.end_z[EFF-1:0]));
    assign cenx  = DW'(signed'(ram_rdata[EFF-1:0]));
    assign ceny  = DW'(signed'(ram_rdata[2*EFF-1:EFF]));
    assign cenz  = DW'(signed'(ram_rdata[3*EFF-1:2*EFF]));
    assign esize = ram_rdata[WORD_W-1:3*EFF];

    assign wx = cenx - sx;
    assign wy = ceny - sy;
    assign wz = cenz - sz;
    assign vx = cenx - ex;
    assign vy = ceny - ey;
    assign vz = cenz - ez;
    assign dx = ex - sx;
    assign dy = ey - sy;
    assign dz = ez - sz;

    assign lim_e = 18'(q_reg.probe_radius) + 18'(esize) + 18'(margin_reg);
    assign lim_b = 18'(q_reg.probe_radius) + 18'(bsize_reg) + 18'(margin_reg);

    assign mag_x = cx_reg[34] ? 34'(-cx_reg) : cx_reg[33:0];
    assign mag_y = cy_reg[34] ? 34'(-cy_reg) : cy_reg[33:0];
    assign mag_z = cz_reg[34] ? 34'(-cz_reg) : cz_reg[33:0];

    assign is_point = q_reg.cmd == soct_pkg::CMD_POINT;
    assign full     = count_reg >= CW'(TABLE_DEPTH);
    assign last     = (idx_reg + CW'(1)) == count_reg;

    // Operand table for the multiplier.
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            opnd[i] = '0;
        end
        opnd[SRC_WX]   = OW'(wx);
        opnd[SRC_WY]   = OW'(wy);
        opnd[SRC_WZ]   = OW'(wz);
        opnd[SRC_DX]   = OW'(dx);
        opnd[SRC_DY]   = OW'(dy);
        opnd[SRC_DZ]   = OW'(dz);
        opnd[SRC_VX]   = OW'(vx);
        opnd[SRC_VY]   = OW'(vy);
        opnd[SRC_VZ]   = OW'(vz);
        opnd[SRC_LIM]  = $signed({1'b0, lim_e});
        opnd[SRC_LIMB] = $signed({1'b0, lim_b});
        opnd[SRC_L2LO] = $signed({1'b0, lim2_reg[17:0]});
        opnd[SRC_L2HI] = $signed({1'b0, lim2_reg[35:18]});
        opnd[SRC_DDLO] = $signed({1'b0, dd_reg[17:0]});
        opnd[SRC_DDHI] = $signed({3'b000, dd_reg[33:18]});
        opnd[SRC_CXLO] = $signed({1'b0, mag_x[17:0]});
        opnd[SRC_CXHI] = $signed({3'b000, mag_x[33:18]});
        opnd[SRC_CYLO] = $signed({1'b0, mag_y[17:0]});
        opnd[SRC_CYHI] = $signed({3'b000, mag_y[33:18]});
        opnd[SRC_CZLO] = $signed({1'b0, mag_z[17:0]});
        opnd[SRC_CZHI] = $signed({3'b000, mag_z[33:18]});
    end

    // Issue one multiply in the first cycle of each step.
    always_comb
    begin
        cur            = step_decode(step_reg);
        op_a           = opnd[cur.asel];
        op_b           = opnd[cur.bsel];
        mac_ctrl.valid = !phase_reg && (state_reg == ST_PREP || state_reg == ST_CALC ||
                                        state_reg == ST_FINAL);
        mac_ctrl.clr   = cur.clr;
        mac_ctrl.neg   = cur.neg;
        mac_ctrl.sh    = cur.sh;
    end

    // Table write port.
    assign ram_we    = state_reg == ST_IDLE && start && item.cmd == soct_pkg::CMD_INSERT &&
                       !full;
    assign ram_wdata = {item.probe_radius, item.start_z[EFF-1:0], item.start_y[EFF-1:0],
                        item.start_x[EFF-1:0]};
    assign ram_re    = state_reg == ST_READ;

    soct_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    soct_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .a        (op_a),
        .b        (op_b),
        .acc_next (acc_next)
    );

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        margin_next = margin_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        q_next      = q_reg;
        lim2_next   = lim2_reg;
        dd_next     = dd_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cz_next     = cz_reg;
        best_next   = best_reg;
        bsize_next  = bsize_reg;
        ent_done    = 1'b0;
        ent_hit     = 1'b0;

        if (cfg_valid)
        begin
            margin_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    q_next = item;
                    if (item.cmd == soct_pkg::CMD_INSERT)
                    begin
                        done_next            = 1'b1;
                        res_next.answer      = 1'b0;
                        res_next.table_full  = full;
                        if (!full)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // An empty table never hits.
                        done_next           = 1'b1;
                        res_next.answer     = item.cmd == soct_pkg::CMD_SIGHT;
                        res_next.table_full = 1'b0;
                    end
                    else if (item.cmd == soct_pkg::CMD_POINT)
                    begin
                        state_next = ST_READ;
                        idx_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                        step_next  = STEP_DD;
                        phase_next = 1'b0;
                    end
                end
            end
            ST_PREP:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (step_reg == STEP_DD_END)
                    begin
                        dd_next    = acc_next[33:0];
                        state_next = ST_READ;
                        idx_next   = '0;
                    end
                    else
                    begin
                        step_next = step_reg + 6'd1;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
                phase_next = 1'b0;
                step_next  = is_point ? STEP_SQW : STEP_LIM2;
            end
            ST_CALC:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    step_next = step_reg + 6'd1;
                    case (step_reg)
                        STEP_LIM2:
                        begin
                            lim2_next = acc_next[35:0];
                        end
                        STEP_WD_END:
                        begin
                            // Pick the closest feature of the segment.
                            if (acc_next[AC-1] || acc_next == '0)
                            begin
                                step_next = STEP_SQW;
                            end
                            else if (acc_next >= AC'(dd_reg))
                            begin
                                step_next = STEP_SQV;
                            end
                            else
                            begin
                                step_next = STEP_CROSS;
                            end
                        end
                        STEP_SQW_END:
                        begin
                            ent_done = 1'b1;
                            if (is_point)
                            begin
                                if (idx_reg == '0 || acc_next[33:0] < best_reg)
                                begin
                                    best_next  = acc_next[33:0];
                                    bsize_next = esize;
                                end
                            end
                            else
                            begin
                                ent_hit = acc_next[35:0] < lim2_reg;
                            end
                        end
                        STEP_SQV_END:
                        begin
                            ent_done = 1'b1;
                            ent_hit  = acc_next[35:0] < lim2_reg;
                        end
                        STEP_CX_SAVE:
                        begin
                            cx_next = acc_next[34:0];
                        end
                        STEP_CY_SAVE:
                        begin
                            cy_next = acc_next[34:0];
                        end
                        STEP_CZ_SAVE:
                        begin
                            cz_next = acc_next[34:0];
                        end
                        STEP_CMP_END:
                        begin
                            ent_done = 1'b1;
                            ent_hit  = !acc_next[AC-1] && acc_next != '0;
                        end
                        default:
                        begin
                        end
                    endcase

                    // Move to the next entry or finish the scan.
                    if (ent_done)
                    begin
                        if (ent_hit)
                        begin
                            state_next          = ST_IDLE;
                            done_next           = 1'b1;
                            res_next.answer     = q_reg.cmd == soct_pkg::CMD_SEG;
                            res_next.table_full = 1'b0;
                        end
                        else if (last)
                        begin
                            if (is_point)
                            begin
                                state_next = ST_FINAL;
                                step_next  = STEP_PT;
                            end
                            else
                            begin
                                state_next          = ST_IDLE;
                                done_next           = 1'b1;
                                res_next.answer     = q_reg.cmd == soct_pkg::CMD_SIGHT;
                                res_next.table_full = 1'b0;
                            end
                        end
                        else
                        begin
                            idx_next   = idx_reg + CW'(1);
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_FINAL:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    state_next          = ST_IDLE;
                    done_next           = 1'b1;
                    res_next.answer     = AC'(best_reg) <= acc_next;
                    res_next.table_full = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= STEP_LIM2;
            phase_reg  <= 1'b0;
            idx_reg    <= '0;
            count_reg  <= '0;
            margin_reg <= soct_pkg::MARGIN_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            margin_reg <= margin_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        q_reg     <= q_next;
        lim2_reg  <= lim2_next;
        dd_reg    <= dd_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        best_reg  <= best_next;
        bsize_reg <= bsize_next;
    end

    // Checks on the sequencer.
    `SOCT_ASSERT_IMPL(a_done_cause, done, $past(busy) || $past(start))
    `SOCT_ASSERT_IMPL(a_read_in_range, state_reg == ST_READ, idx_reg < count_reg)
    `SOCT_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(TABLE_DEPTH))
    `SOCT_ASSERT_IMPL(a_full_no_answer, done && result.table_full, !result.answer)

endmodule

`default_nettype wire

### hw/rtl/soct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module soct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/soct_mac.sv
// Shared multiply-accumulate unit: a registered signed multiplier followed by
// a shifting accumulator. Depends on soct_pkg.
`default_nettype none

module soct_mac (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire soct_pkg::mac_ctrl_t               ctrl,
    input  wire logic signed [soct_pkg::OP_W-1:0]  a,
    input  wire logic signed [soct_pkg::OP_W-1:0]  b,
    output logic signed [soct_pkg::ACC_W-1:0]      acc_next
);

    soct_pkg::mac_ctrl_t                   ctrl_reg;
    logic signed [soct_pkg::PROD_W-1:0]    prod_reg;
    logic signed [soct_pkg::ACC_W-1:0]     acc_reg;
    logic signed [soct_pkg::ACC_W-1:0]     ext;
    logic signed [soct_pkg::ACC_W-1:0]     shifted;
    logic signed [soct_pkg::ACC_W-1:0]     base;

    // Control of the step in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl;
        end
    end

    // Product and accumulator registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    // Align the product and add or subtract it.
    always_comb
    begin
        ext = soct_pkg::ACC_W'(prod_reg);
        case (ctrl_reg.sh)
            soct_pkg::SH_0:  shifted = ext;
            soct_pkg::SH_18: shifted = ext <<< 18;
            soct_pkg::SH_19: shifted = ext <<< 19;
            soct_pkg::SH_36: shifted = ext <<< 36;
            default:         shifted = ext;
        endcase
        base = ctrl_reg.clr ? '0 : acc_reg;
        if (!ctrl_reg.valid)
        begin
            acc_next = acc_reg;
        end
        else if (ctrl_reg.neg)
        begin
            acc_next = base - shifted;
        end
        else
        begin
            acc_next = base + shifted;
        end
    end

endmodule

`default_nettype wire
